@@ rtl/sparse_neighbor_cell_counter_defines.svh @@
// ---------------------------------------------------------------------------
// sparse_neighbor_cell_counter_defines
// Assertion macros shared by the sparse neighbour cell counter
// ---------------------------------------------------------------------------
`ifndef SPARSE_NEIGHBOR_CELL_COUNTER_DEFINES_SVH
`define SPARSE_NEIGHBOR_CELL_COUNTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SNC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("snc assertion failed");

// next-cycle implication, checked out of reset
`define SNC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("snc assertion failed");

`endif

@@ rtl/snc_pkg.sv @@
// ---------------------------------------------------------------------------
// snc_pkg
// Types and constants of the sparse neighbour cell counter
// ---------------------------------------------------------------------------
package snc_pkg;

    localparam int          SNC_MAX_WIDTH = 256;
    localparam logic [7:0]  OCCUPIED_MARK = 8'h40;
    localparam logic [3:0]  SPARSE_LIMIT  = 4'd4;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_DRAIN,
        ST_DONE
    } snc_state_t;

    // one column of the 3x3 window
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } col_t;

    // one line buffer cell: the two rows above the current one
    typedef struct packed {
        logic upper;
        logic lower;
    } line_t;

    // judge control for one window step
    typedef struct packed {
        logic jn;
        logic je;
        logic lm;
        logic em;
    } judge_ctl_t;

endpackage

@@ rtl/sparse_neighbor_cell_counter.sv @@
// ---------------------------------------------------------------------------
// sparse_neighbor_cell_counter
// Counts occupied grid cells with fewer than four occupied neighbours
// ---------------------------------------------------------------------------
// Cells of an n by n grid (n from the grid size register, zero read as one,
// capped at the smaller of MAX_WIDTH and 255) are taken one per cycle in row
// order while the block is in its run state and input is valid. The two rows
// above the current one sit in a chain of MAX_WIDTH two-bit cells that shifts
// once per cell, so the window moves one column per cell. After the last cell
// the block takes no cells while the chain is run once more with an empty row
// to judge the bottom row, then passes through the drain and done states to
// settle the total. The total waits in an output register while the next grid
// streams in. The chain needs no clearing after reset. A grid size write restarts the grid.
// ---------------------------------------------------------------------------
module sparse_neighbor_cell_counter
    import snc_pkg::*;
#(
    parameter int MAX_WIDTH = SNC_MAX_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,   // grid_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // cell_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // sparse_total
);

`include "sparse_neighbor_cell_counter_defines.svh"

    localparam int         CAP_INT  = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
    localparam logic [7:0] SIZE_CAP = 8'(CAP_INT);

    snc_state_t  state_reg, state_next;
    logic [7:0]  grid_size_reg;
    logic [7:0]  col_reg;
    logic [7:0]  row_reg;
    logic [15:0] total_reg, total_next;
    logic [15:0] out_data_reg;
    logic        out_valid_reg;
    judge_ctl_t  ctl_reg, ctl_next;
    col_t        win_reg [3];

    logic        cfg_we, in_acc, step, out_load;
    logic [7:0]  tail_col, cfg_size_eff;
    logic        last_col, last_row, cur_bit, row_zero;
    col_t        trio, left_n, left_e;
    line_t       line_in;
    line_t       chain [MAX_WIDTH];
    logic        hit_n, hit_e;
    logic [1:0]  inc;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign in_acc    = s_tvalid && s_tready;
    assign step      = in_acc || (state_reg == ST_FLUSH);

    assign cfg_size_eff = (cfg_data == 8'd0)    ? 8'd1 :
                          (cfg_data > SIZE_CAP) ? SIZE_CAP : cfg_data;

    assign tail_col = grid_size_reg - 8'd1;
    assign last_col = (col_reg == tail_col);
    assign last_row = (row_reg == tail_col);
    assign row_zero = (row_reg == 8'd0);
    assign cur_bit  = (state_reg == ST_RUN) && (s_tdata == OCCUPIED_MARK);

    // rows above the top of the grid read as empty
    assign trio.bot      = cur_bit;
    assign trio.mid      = row_zero ? 1'b0 : chain[0].upper;
    assign trio.top      = row_zero ? 1'b0 : chain[0].lower;
    assign line_in.upper = cur_bit;
    assign line_in.lower = trio.mid;

    // line buffer chain
    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_line
        line_t nbr;
        if (k == MAX_WIDTH - 1) begin : g_end
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = chain[k + 1];
        end
        snc_line_cell u_cell (
            .aclk      (aclk),
            .shift_en  (step),
            .load_sel  (32'(tail_col) == k),
            .load_bits (line_in),
            .next_bits (nbr),
            .bits      (chain[k])
        );
    end

    // window judges: inner cell and row end cell
    assign left_n = ctl_reg.lm ? '0 : win_reg[0];
    assign left_e = ctl_reg.em ? '0 : win_reg[1];

    snc_judge u_judge_inner (
        .left   (left_n),
        .centre (win_reg[1]),
        .right  (win_reg[2]),
        .hit    (hit_n)
    );

    snc_judge u_judge_end (
        .left   (left_e),
        .centre (win_reg[2]),
        .right  ('0),
        .hit    (hit_e)
    );

    assign inc        = 2'(hit_n && ctl_reg.jn) + 2'(hit_e && ctl_reg.je);
    assign total_next = total_reg + 16'(inc);

    always_comb begin
        ctl_next.jn = step && !cfg_we && !row_zero && (col_reg != 8'd0);
        ctl_next.je = step && !cfg_we && !row_zero && last_col;
        ctl_next.lm = (col_reg == 8'd1);
        ctl_next.em = (col_reg == 8'd0);
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        s_tready   = (state_reg == ST_RUN);
        case (state_reg)
            ST_RUN: begin
                if (in_acc && last_col && last_row) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (last_col) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
        if (cfg_we) begin
            state_next = ST_RUN;
            out_load   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= 8'd1;
            col_reg       <= 8'd0;
            row_reg       <= 8'd0;
            total_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
            ctl_reg       <= '0;
        end else begin
            ctl_reg <= ctl_next;
            if (cfg_we) begin
                grid_size_reg <= cfg_size_eff;
                col_reg       <= 8'd0;
                row_reg       <= 8'd0;
                total_reg     <= 16'd0;
            end else begin
                if (step) begin
                    if (last_col) begin
                        col_reg <= 8'd0;
                        row_reg <= (state_reg == ST_FLUSH) ? 8'd0 : row_reg + 8'd1;
                    end else begin
                        col_reg <= col_reg + 8'd1;
                    end
                end
                total_reg <= out_load ? 16'd0 : total_next;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= trio;
        end
        if (out_load) begin
            out_data_reg <= total_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SNC_ASSERT_NOW(a_col_in_grid, 1'b1, col_reg < grid_size_reg)
    `SNC_ASSERT_NOW(a_run_row_in_grid, state_reg == ST_RUN, row_reg < grid_size_reg)
    `SNC_ASSERT_NEXT(a_flush_moves_on, (state_reg == ST_FLUSH) && !cfg_we, (state_reg == ST_FLUSH) || (state_reg == ST_DRAIN))
    `SNC_ASSERT_NEXT(a_drain_to_done, (state_reg == ST_DRAIN) && !cfg_we, state_reg == ST_DONE)
    `SNC_ASSERT_NEXT(a_done_gives_word, out_load, m_tvalid && (total_reg == 16'd0))

endmodule

@@ rtl/snc_line_cell.sv @@
// ---------------------------------------------------------------------------
// snc_line_cell
// One cell of the line buffer chain, loads at the tail or takes its neighbour
// ---------------------------------------------------------------------------
module snc_line_cell
    import snc_pkg::*;
(
    input  logic  aclk,
    input  logic  shift_en,
    input  logic  load_sel,
    input  line_t load_bits,
    input  line_t next_bits,
    output line_t bits
);

    line_t bits_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            bits_reg <= load_sel ? load_bits : next_bits;
        end
    end

    assign bits = bits_reg;

endmodule

@@ rtl/snc_judge.sv @@
// ---------------------------------------------------------------------------
// snc_judge
// Tests the centre of a 3x3 window for an occupied cell with few neighbours
// ---------------------------------------------------------------------------
module snc_judge
    import snc_pkg::*;
(
    input  col_t left,
    input  col_t centre,
    input  col_t right,
    output logic hit
);

    logic [3:0] count;

    assign count = 4'(left.top) + 4'(left.mid) + 4'(left.bot)
                 + 4'(centre.top) + 4'(centre.bot)
                 + 4'(right.top) + 4'(right.mid) + 4'(right.bot);

    assign hit = centre.mid && (count < SPARSE_LIMIT);

endmodule
